// ===== design/cf2d_pkg.sv =====
// Shared types and constants of the custom float to binary64 converter.
`timescale 1ns / 1ps
package cf2d_pkg;

  typedef enum logic [2:0] {
    CLS_ZERO    = 3'd0,
    CLS_SUBNORM = 3'd1,
    CLS_NORMAL  = 3'd2,
    CLS_INF     = 3'd3,
    CLS_NAN     = 3'd4,
    CLS_INVALID = 3'd5
  } value_class_t;

  localparam logic [1:0] REG_TOTAL_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRACTION_WIDTH = 2'd1;

  localparam logic [63:0] D_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] D_INF  = 64'h7FF0_0000_0000_0000;

  localparam logic [6:0] TOTAL_WIDTH_RST    = 7'd32;
  localparam logic [5:0] FRACTION_WIDTH_RST = 6'd23;

endpackage

// ===== design/cf2d_if.sv =====
// Valid/ready channel interfaces for raw words and binary64 results.
`timescale 1ns / 1ps
interface cf2d_in_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] raw_word;
  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

interface cf2d_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] double_bits;
  logic [2:0]  value_class;
  logic        inexact;
  modport source (output valid, output double_bits, output value_class, output inexact,
                  input ready);
  modport sink   (input valid, input double_bits, input value_class, input inexact,
                  output ready);
endinterface

// ===== design/custom_float_to_binary64.sv =====
// Top level: pipelined converter from a configurable float format to binary64.
`timescale 1ns / 1ps
// Each accepted beat passes the stage 1, 2 and 3 registers on its way to dbl.
// Throughput: one beat per cycle while dbl is not stalled; the three stages
// advance together whenever the output register is empty or its beat is taken,
// so a stall loses nothing. Reset (rst, synchronous): clears all stage valid
// bits, total_width to 32 and fraction_width to 23.
module custom_float_to_binary64
  import cf2d_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  cf2d_in_if.sink    raw,
  cf2d_out_if.source dbl
);

  // Configuration registers
  logic [6:0] total_width;
  logic [5:0] fraction_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_width    <= TOTAL_WIDTH_RST;
      fraction_width <= FRACTION_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOTAL_WIDTH) total_width <= cfg_data;
      if (cfg_index == REG_FRACTION_WIDTH) fraction_width <= cfg_data[5:0];
    end
  end

  // All stages move together; the output register frees up when taken.
  logic adv;
  logic v1, v2, v3;
  assign adv       = !v3 || dbl.ready;
  assign raw.ready = adv;

  // ---------------- Stage 1: unpack fields, classify, base exponent
  logic [63:0] word_ext, word, wmask, emask, fmask, ex, fr, bias;
  logic [6:0]  ew;
  logic        fmt_ok, sgn_c;
  logic signed [64:0] x0_c;
  value_class_t cls_c;
  logic        spec_c;
  logic [63:0] sbits_c, m_c;

  always_comb begin
    word_ext = 64'(raw.raw_word);
    fmt_ok = (total_width >= 7'd8) && (32'(total_width) <= WORD_BITS) &&
             (fraction_width != 6'd0) && ((7'(fraction_width) + 7'd1) < total_width);
    ew    = total_width - 7'(fraction_width) - 7'd1;
    wmask = ~(~64'd0 << total_width);
    word  = word_ext & wmask;
    sgn_c = word[6'(total_width - 7'd1)];
    emask = ~(~64'd0 << ew);
    fmask = ~(~64'd0 << fraction_width);
    ex    = (word >> fraction_width) & emask;
    fr    = word & fmask;
    bias  = (64'd1 << (ew - 7'd1)) - 64'd1;
    spec_c  = 1'b1;
    sbits_c = 64'd0;
    m_c     = fr;
    x0_c    = 65'sd1 - $signed({1'b0, bias}) - $signed(65'(fraction_width));
    if (!fmt_ok) begin
      cls_c = CLS_INVALID;
    end else if (ex == emask) begin
      if (fr == 64'd0) begin
        cls_c   = CLS_INF;
        sbits_c = D_INF | {sgn_c, 63'd0};
      end else begin
        cls_c   = CLS_NAN;
        sbits_c = D_QNAN;
      end
    end else if (ex == 64'd0) begin
      if (fr == 64'd0) begin
        cls_c = CLS_ZERO;
      end else begin
        cls_c  = CLS_SUBNORM;
        spec_c = 1'b0;
      end
    end else begin
      cls_c  = CLS_NORMAL;
      spec_c = 1'b0;
      m_c    = fr | (64'd1 << fraction_width);
      x0_c   = $signed({1'b0, ex}) - $signed({1'b0, bias});
    end
  end

  value_class_t cls1;
  logic        sgn1, spec1, sub1;
  logic [63:0] sbits1, m1;
  logic signed [64:0] x01;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= raw.valid;
    if (adv) begin
      cls1   <= cls_c;
      sgn1   <= sgn_c;
      spec1  <= spec_c;
      sub1   <= (cls_c == CLS_SUBNORM);
      sbits1 <= sbits_c;
      m1     <= m_c;
      x01    <= x0_c;
    end
  end

  // ---------------- Stage 2: normalize, true exponent, saturate
  logic [5:0]  lz;
  logic [63:0] n_c;
  logic signed [64:0] x_c;
  logic        ovf_c;
  logic signed [11:0] xs_c;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m1[i]) lz = 6'(63 - i);
    end
    n_c   = m1 << lz;
    x_c   = sub1 ? (x01 + $signed({59'd0, 6'd63 - lz})) : x01;
    ovf_c = x_c > 65'sd1023;
    xs_c  = (x_c < -65'sd1200) ? -12'sd1200 : 12'(x_c);
  end

  value_class_t cls2;
  logic        sgn2, spec2, ovf2;
  logic [63:0] sbits2, n2;
  logic signed [11:0] xs2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      cls2   <= cls1;
      sgn2   <= sgn1;
      spec2  <= spec1;
      ovf2   <= ovf_c;
      sbits2 <= sbits1;
      n2     <= n_c;
      xs2    <= xs_c;
    end
  end

  // ---------------- Stage 3: denormalizing shift, round to nearest-even, pack
  logic        normal3, g3, st3, inx_c;
  logic signed [11:0] d3;
  logic [7:0]  t3;
  logic [127:0] v128;
  logic [53:0] rr;
  logic [10:0] e0;
  logic [62:0] sum;
  logic [63:0] bits_c;

  always_comb begin
    normal3 = xs2 >= -12'sd1022;
    d3      = -12'sd1022 - xs2;
    if (normal3) t3 = 8'd11;
    else if (d3 > 12'sd54) t3 = 8'd65;
    else t3 = 8'd11 + 8'(d3);
    v128 = {n2, 64'd0} >> t3;
    g3   = v128[63];
    st3  = |v128[62:0];
    rr   = 54'(v128[116:64]) + 54'(g3 & (st3 | v128[64]));
    e0   = normal3 ? 11'(xs2 + 12'sd1022) : 11'd0;
    sum  = {e0, 52'd0} + 63'(rr);
    inx_c  = g3 | st3;
    bits_c = {sgn2, sum};
    if (spec2) begin
      bits_c = sbits2;
      inx_c  = 1'b0;
    end else if (ovf2 || sum[62:52] == 11'h7FF) begin
      bits_c = D_INF | {sgn2, 63'd0};
      inx_c  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      dbl.double_bits <= bits_c;
      dbl.value_class <= cls2;
      dbl.inexact     <= inx_c;
    end
  end

  assign dbl.valid = v3;

  // Special classes leave the pipe with their fixed patterns.
  a_nan: assert property (@(posedge clk) disable iff (rst)
    v3 && dbl.value_class == CLS_NAN |-> dbl.double_bits == D_QNAN && !dbl.inexact)
    else $error("nan result not canonical");
  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    v3 && (dbl.value_class == CLS_ZERO || dbl.value_class == CLS_INVALID)
    |-> dbl.double_bits == 64'd0 && !dbl.inexact)
    else $error("zero or invalid result not clean");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    v3 && !dbl.ready |=> v3 && $stable(dbl.double_bits))
    else $error("output beat lost under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && v2 |=> v3)
    else $error("beat dropped between stages");

endmodule

// ===== verif/cf2d_checker.sv =====
// Checker for the float to binary64 converter: predicts each result and compares.
`timescale 1ns / 1ps
module cf2d_checker
  import cf2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  cf2d_in_if.sink    raw_mon,
  cf2d_out_if.sink   dbl_mon,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  typedef struct packed {
    logic [63:0]  bits;
    value_class_t cls;
    logic         inexact;
  } dbl_result_t;

  dbl_result_t expected_q[$];
  logic [6:0] tw;
  logic [5:0] fw;

  assign pending = expected_q.size();

  // Round (sign) m * 2^e once to binary64, nearest-even.
  function automatic dbl_result_t round_to_double(logic s, logic [63:0] m, longint e);
    dbl_result_t r;
    longint p, x, q, sh;
    logic [63:0] rem, half, mant;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    r.cls = CLS_NORMAL;
    r.inexact = 0;
    x = p + e;
    if (x > 1023) begin
      r.bits = {s, 63'd0} | D_INF;
      r.inexact = 1;
      return r;
    end
    q = x - 52;
    if (q < -1074) q = -1074;
    sh = q - e;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else if (sh >= 64) begin
      mant = 0;
      r.inexact = 1;
    end else begin
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      mant = m >> sh;
      r.inexact = rem != 0;
      if (rem > half || (rem == half && mant[0])) mant++;
    end
    if (mant == (64'd1 << 53)) begin
      mant = mant >> 1;
      q++;
    end
    if (mant < (64'd1 << 52)) begin
      r.bits = {s, 63'd0} | mant;
    end else if (q + 52 + 1023 >= 2047) begin
      r.bits = {s, 63'd0} | D_INF;
      r.inexact = 1;
    end else begin
      r.bits = {s, 11'(q + 52 + 1023), mant[51:0]};
    end
    return r;
  endfunction

  function automatic dbl_result_t convert_word(logic [63:0] w_in);
    dbl_result_t r;
    longint ew, bias;
    logic [63:0] word, ex, fr, emax;
    logic s;
    r = '{bits: 0, cls: CLS_INVALID, inexact: 0};
    if (tw < 8 || tw > 64 || fw < 1 || fw + 1 >= tw) return r;
    ew = tw - fw - 1;
    word = (tw == 64) ? w_in : (w_in & ((64'd1 << tw) - 1));
    s = word[tw-1];
    emax = (64'd1 << ew) - 1;
    ex = (word >> fw) & emax;
    fr = word & ((64'd1 << fw) - 1);
    bias = (longint'(1) << (ew - 1)) - 1;
    if (ex == emax) begin
      if (fr == 0) r = '{bits: {s, 63'd0} | D_INF, cls: CLS_INF, inexact: 0};
      else r = '{bits: D_QNAN, cls: CLS_NAN, inexact: 0};
    end else if (ex == 0) begin
      if (fr == 0) r = '{bits: 0, cls: CLS_ZERO, inexact: 0};
      else begin
        r = round_to_double(s, fr, 1 - bias - longint'(fw));
        r.cls = CLS_SUBNORM;
      end
    end else begin
      r = round_to_double(s, (64'd1 << fw) | fr, longint'(ex) - bias - longint'(fw));
      r.cls = CLS_NORMAL;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    dbl_result_t want;
    if (rst) begin
      tw <= TOTAL_WIDTH_RST;
      fw <= FRACTION_WIDTH_RST;
    end else begin
      if (cfg_we && cfg_index == REG_TOTAL_WIDTH) tw <= cfg_data;
      if (cfg_we && cfg_index == REG_FRACTION_WIDTH) fw <= cfg_data[5:0];
      if (raw_mon.valid && raw_mon.ready) expected_q.push_back(convert_word(raw_mon.raw_word));
      if (dbl_mon.valid && dbl_mon.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", dbl_mon.double_bits, 0);
        end else begin
          want = expected_q.pop_front();
          if (dbl_mon.double_bits !== want.bits)
            report_mismatch("double_bits", dbl_mon.double_bits, want.bits);
          if (dbl_mon.value_class !== want.cls)
            report_mismatch("value_class", dbl_mon.value_class, want.cls);
          if (dbl_mon.inexact !== want.inexact)
            report_mismatch("inexact", dbl_mon.inexact, want.inexact);
        end
      end
    end
  end

endmodule

// ===== verif/custom_float_to_binary64_test.sv =====
// Testbench top: drives words and config, throttles both channels, gives the verdict.
`timescale 1ns / 1ps
module custom_float_to_binary64_test;
  import cf2d_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [1:0] cfg_index = REG_TOTAL_WIDTH;
  logic [6:0] cfg_data = 0;
  int         fail_count, pending, results_seen;
  int         idle_cycles = 0;
  int         words_sent = 0;
  bit         stim_done = 0;

  cf2d_in_if  raw_ch ();
  cf2d_out_if dbl_ch ();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  custom_float_to_binary64 u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .raw(raw_ch.sink), .dbl(dbl_ch.source)
  );

  cf2d_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .raw_mon(raw_ch.sink), .dbl_mon(dbl_ch.sink),
    .fail_count, .pending, .results_seen
  );

  initial begin
    raw_ch.valid = 0;
    raw_ch.raw_word = 0;
    dbl_ch.ready = 0;
  end

  // Result side: draw a stall per beat, with no-stall stretches now and then.
  // Keep ready high straight through when the drawn stall is zero.
  initial begin
    int stall;
    @(posedge clk iff !rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        dbl_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      dbl_ch.ready <= 1;
      @(posedge clk iff dbl_ch.valid);
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((raw_ch.valid && raw_ch.ready) || (dbl_ch.valid && dbl_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one beat; gap is drawn unless the caller forces back-to-back.
  // Valid stays high into the next beat when there is no gap.
  task automatic send_word(logic [63:0] w, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      raw_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    raw_ch.valid <= 1;
    raw_ch.raw_word <= w;
    @(posedge clk iff raw_ch.ready);
    words_sent++;
  endtask

  // Drop valid, hold until the converter has drained, then let its pipeline settle.
  task automatic drain();
    raw_ch.valid <= 0;
    @(posedge clk iff pending == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_format(logic [6:0] total, logic [6:0] frac);
    drain();
    cfg_we <= 1;
    cfg_index <= REG_TOTAL_WIDTH;
    cfg_data <= total;
    @(posedge clk);
    cfg_index <= REG_FRACTION_WIDTH;
    cfg_data <= frac;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Build a word for format (tw, fw) with a chosen exponent flavor and random fraction.
  function automatic logic [63:0] shaped_word(int tw, int fw);
    logic [63:0] w, fmask, emax;
    int ew, kind;
    ew = tw - fw - 1;
    fmask = (64'd1 << fw) - 1;
    emax = (64'd1 << ew) - 1;
    w = rand64();
    kind = $urandom_range(0, 9);
    case (kind)
      0: w = (w & ~(emax << fw));                      // subnormal or zero
      1: w = (w | (emax << fw));                       // inf or nan
      2: w = (w & ~(emax << fw)) | (emax << fw) & ~(fmask) & ~(64'd1 << fw) | (w & 0);
      3: w = w & ~fmask;                               // exact fraction
      4: w = w | fmask;                                // rounding carries
      default: ;
    endcase
    return w;
  endfunction

  typedef struct { int tw; int fw; } fmt_t;

  initial begin
    fmt_t fmts[$];
    fmt_t f;
    int per_fmt;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset format is binary32.
    send_word(64'h0000_0000, 0);           // zero
    send_word(64'h8000_0000, 1);           // negative zero gives +0
    send_word(64'h0000_0001, 1);           // smallest subnormal
    send_word(64'h807F_FFFF, 1);           // largest negative subnormal
    send_word(64'h3F80_0000, 1);           // one
    send_word(64'h7F7F_FFFF, 1);           // largest normal
    send_word(64'h7F80_0000, 0);           // infinity
    send_word(64'hFF80_0000, 1);           // negative infinity
    send_word(64'hFFC0_0001, 1);           // nan with sign
    send_word(64'hFFFF_FFFF_3F80_0000, 0); // upper bits ignored
    // Wide format with 15-bit exponent: overflow, underflow, rounding.
    write_format(7'd64, 7'd48);
    send_word(64'h7FFE_FFFF_FFFF_FFFF, 0);
    send_word(64'hFFFE_0000_0000_0001, 1);
    send_word(64'h0000_0000_0000_0001, 1);
    send_word(64'h0000_FFFF_FFFF_FFFF, 0);
    send_word(64'h3BCD_0000_0000_0001, 1);
    // Extreme and invalid formats.
    write_format(7'd8, 7'd6);
    send_word(64'hFF, 0);
    send_word(64'h41, 0);
    write_format(7'd8, 7'd7);
    send_word(64'h55, 0);
    write_format(7'd7, 7'd3);
    send_word(64'h12, 0);
    write_format(7'd65, 7'd20);
    send_word(64'h12, 0);
    write_format(7'd20, 7'd0);
    send_word(64'h12, 0);
    // Register index beyond 1 must be ignored.
    drain();
    cfg_we <= 1;
    cfg_index <= 2'd3;
    cfg_data <= 7'd8;
    @(posedge clk);
    cfg_we <= 0;
    send_word(64'h12, 0);

    // Random formats, including the extremes, most of them valid.
    fmts.push_back('{64, 62});
    fmts.push_back('{64, 1});
    fmts.push_back('{8, 1});
    fmts.push_back('{16, 10});
    fmts.push_back('{64, 52});
    fmts.push_back('{32, 23});
    fmts.push_back('{40, 20});
    for (int i = 0; i < 11; i++) begin
      int t;
      t = $urandom_range(8, 64);
      fmts.push_back('{t, $urandom_range(1, t - 2)});
    end
    fmts.push_back('{$urandom_range(0, 127), $urandom_range(0, 63)});
    per_fmt = 1850 / fmts.size();
    foreach (fmts[k]) begin
      f = fmts[k];
      write_format(f.tw[6:0], f.fw[6:0]);
      for (int i = 0; i < per_fmt; i++) begin
        bit burst;
        burst = (i % 200) < 40;
        if (f.tw >= 8 && f.tw <= 64 && f.fw >= 1 && f.fw < f.tw - 1 && $urandom_range(0, 4) != 0)
          send_word(shaped_word(f.tw, f.fw), burst);
        else
          send_word(rand64(), burst);
      end
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d words across directed formats and 19 random formats", words_sent);
    $display("%0d result beats checked", results_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== custom_float_to_binary64.f =====
design/cf2d_pkg.sv
design/cf2d_if.sv
design/custom_float_to_binary64.sv
verif/cf2d_checker.sv
verif/custom_float_to_binary64_test.sv
